>>> rtl/eapd_pkg.sv
// package for the embedded audio packet decoder
// holds command and result types, opcodes and sizes; no dependencies
`default_nettype none

package eapd_pkg;

    // group count and register sizes
    localparam int NUM_GROUPS = 4;
    localparam int ID_W       = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int QDEPTH     = 4;
    localparam int QAW        = 2;

    // packet kinds of the front parser
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_AUDIO   = 2'd2;
    localparam logic [1:0] KIND_CONTROL = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_ID_G1   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_ID_G1 = 3'd4;

    // word positions inside a packet
    localparam logic [4:0] POS_DID       = 5'd3;
    localparam logic [4:0] POS_BLOCK     = 5'd4;
    localparam logic [4:0] POS_CLK_LO    = 5'd6;
    localparam logic [4:0] POS_CLK_HI    = 5'd7;
    localparam logic [4:0] POS_MASK      = 5'd8;
    localparam logic [4:0] POS_FIRST_SMP = 5'd8;
    localparam logic [4:0] POS_LAST_SMP  = 5'd23;
    localparam logic [4:0] POS_MAX       = 5'd31;

    // rate field codes in control word 7
    localparam logic [2:0] RATE_FLD_48K  = 3'b000;
    localparam logic [2:0] RATE_FLD_44K  = 3'b001;
    localparam logic [2:0] RATE_FLD_32K  = 3'b010;
    localparam logic [2:0] RATE_FLD_96K  = 3'b100;
    localparam logic [1:0] RATE_48K      = 2'd0;
    localparam logic [1:0] RATE_44K      = 2'd1;
    localparam logic [1:0] RATE_32K      = 2'd2;
    localparam logic [1:0] RATE_96K      = 2'd3;

    // commands passed from front to back
    localparam logic [2:0] OP_BLOCK  = 3'd0;
    localparam logic [2:0] OP_CLK_LO = 3'd1;
    localparam logic [2:0] OP_CLK_HI = 3'd2;
    localparam logic [2:0] OP_SAMP0  = 3'd3;
    localparam logic [2:0] OP_SAMP1  = 3'd4;
    localparam logic [2:0] OP_SAMP2  = 3'd5;
    localparam logic [2:0] OP_EMIT   = 3'd6;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] grp;
        logic [1:0] chan;
        logic [1:0] rate;
        logic [7:0] data;
    } eapd_cmd_t;

    // result payload, lowest field last
    typedef struct packed {
        logic [1:0]  rate_code;
        logic        multi_frame_flag;
        logic [12:0] audio_clock;
        logic [7:0]  block_number;
        logic        parity_bit;
        logic        status_bit;
        logic        user_bit;
        logic        validity_bit;
        logic [23:0] sample;
    } eapd_result_t;

    localparam int RESULT_W = $bits(eapd_result_t);
    localparam int M_DATA_W = 56;

endpackage

`default_nettype wire

>>> rtl/eapd_front.sv
// front parser: tracks packet words, matches the DID, keeps per-group tables
// and turns audio words into commands for the back end; uses eapd_pkg
`default_nettype none

module eapd_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [eapd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [eapd_pkg::ID_W-1:0]     cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,
    input  wire logic                          s_tuser,
    input  wire logic                          q_full,
    output logic                               q_push,
    output eapd_pkg::eapd_cmd_t                q_cmd
);
    import eapd_pkg::*;

    logic [ID_W-1:0] audio_id_reg   [NUM_GROUPS];
    logic [ID_W-1:0] control_id_reg [NUM_GROUPS];

    logic [4:0] word_count_reg, word_count_next;
    logic [1:0] kind_reg, kind_next;
    logic [1:0] group_reg, group_next;
    logic [NUM_GROUPS-1:0] valid_reg, valid_next;
    logic [1:0] rate_reg [NUM_GROUPS];
    logic [1:0] rate_next [NUM_GROUPS];
    logic [3:0] mask_reg [NUM_GROUPS];
    logic [3:0] mask_next [NUM_GROUPS];

    logic            s_fire;
    logic [ID_W-1:0] w;
    logic [1:0]      kind_cur;
    logic [4:0]      pos;
    logic [4:0]      smp_off;
    logic            active;
    logic            hit_found;
    logic            hit_ctrl;
    logic [1:0]      hit_grp;

    assign s_tready = !q_full;
    assign s_fire   = s_tvalid && s_tready;
    assign w        = s_tdata[ID_W-1:0];

    // did match: lowest group wins, control ids flag control kind
    always_comb begin
        hit_found = 1'b0;
        hit_ctrl  = 1'b0;
        hit_grp   = 2'd0;
        for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
            if (control_id_reg[i] == w) begin
                hit_ctrl = 1'b1;
            end
            if (control_id_reg[i] == w || audio_id_reg[i] == w) begin
                hit_found = 1'b1;
                hit_grp   = 2'(i);
            end
        end
    end

    // per-word parsing
    always_comb begin
        word_count_next = word_count_reg;
        kind_next       = kind_reg;
        group_next      = group_reg;
        valid_next      = valid_reg;
        rate_next       = rate_reg;
        mask_next       = mask_reg;
        q_push          = 1'b0;
        q_cmd.op        = OP_BLOCK;
        q_cmd.grp       = group_reg;
        q_cmd.chan      = 2'd0;
        q_cmd.rate      = rate_reg[group_reg];
        q_cmd.data      = w[7:0];

        kind_cur = s_tuser ? KIND_HEADER : kind_reg;
        pos      = s_tuser ? 5'd0 : word_count_reg;
        active   = s_fire && (kind_cur != KIND_NONE);
        smp_off  = pos - POS_FIRST_SMP;
        q_cmd.chan = smp_off[3:2];

        if (active) begin
            word_count_next = (pos != POS_MAX) ? pos + 5'd1 : POS_MAX;
            kind_next       = kind_cur;
            unique case (kind_cur)
                KIND_HEADER: begin
                    if (pos == POS_DID) begin
                        if (!hit_found) begin
                            kind_next = KIND_NONE;
                        end else begin
                            group_next = hit_grp;
                            if (valid_reg[hit_grp]) begin
                                kind_next = hit_ctrl ? KIND_NONE : KIND_AUDIO;
                            end else begin
                                kind_next = hit_ctrl ? KIND_CONTROL : KIND_NONE;
                            end
                        end
                    end
                end
                KIND_CONTROL: begin
                    if (pos == POS_CLK_HI) begin
                        unique case (w[3:1])
                            RATE_FLD_48K: rate_next[group_reg] = RATE_48K;
                            RATE_FLD_44K: rate_next[group_reg] = RATE_44K;
                            RATE_FLD_32K: rate_next[group_reg] = RATE_32K;
                            RATE_FLD_96K: rate_next[group_reg] = RATE_96K;
                            default:      rate_next[group_reg] = rate_reg[group_reg];
                        endcase
                    end else if (pos == POS_MASK) begin
                        mask_next[group_reg]  = w[3:0];
                        valid_next[group_reg] = 1'b1;
                        kind_next             = KIND_NONE;
                    end
                end
                KIND_AUDIO: begin
                    if (pos == POS_BLOCK) begin
                        q_push   = 1'b1;
                        q_cmd.op = OP_BLOCK;
                    end else if (pos == POS_CLK_LO) begin
                        q_push   = 1'b1;
                        q_cmd.op = OP_CLK_LO;
                    end else if (pos == POS_CLK_HI) begin
                        q_push   = 1'b1;
                        q_cmd.op = OP_CLK_HI;
                    end else if (pos >= POS_FIRST_SMP && pos <= POS_LAST_SMP) begin
                        unique case (smp_off[1:0])
                            2'd0: begin
                                q_push   = 1'b1;
                                q_cmd.op = OP_SAMP0;
                            end
                            2'd1: begin
                                q_push   = 1'b1;
                                q_cmd.op = OP_SAMP1;
                            end
                            2'd2: begin
                                q_push   = 1'b1;
                                q_cmd.op = OP_SAMP2;
                            end
                            default: begin
                                q_push   = mask_reg[group_reg][smp_off[3:2]];
                                q_cmd.op = OP_EMIT;
                            end
                        endcase
                    end
                end
                default: begin
                    kind_next = KIND_NONE;
                end
            endcase
        end
    end

    // id registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            audio_id_reg[0]   <= 10'd743;
            audio_id_reg[1]   <= 10'd486;
            audio_id_reg[2]   <= 10'd485;
            audio_id_reg[3]   <= 10'd740;
            control_id_reg[0] <= 10'd483;
            control_id_reg[1] <= 10'd738;
            control_id_reg[2] <= 10'd737;
            control_id_reg[3] <= 10'd480;
        end else if (cfg_we) begin
            if (cfg_index < REG_CONTROL_ID_G1) begin
                audio_id_reg[2'(cfg_index - REG_AUDIO_ID_G1)] <= cfg_wdata;
            end else begin
                control_id_reg[2'(cfg_index - REG_CONTROL_ID_G1)] <= cfg_wdata;
            end
        end
    end

    // parser state and group tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_count_reg <= 5'd0;
            kind_reg       <= KIND_NONE;
            group_reg      <= 2'd0;
            valid_reg      <= '0;
            for (int i = 0; i < NUM_GROUPS; i++) begin
                rate_reg[i] <= RATE_48K;
                mask_reg[i] <= 4'd0;
            end
        end else begin
            word_count_reg <= word_count_next;
            kind_reg       <= kind_next;
            group_reg      <= group_next;
            valid_reg      <= valid_next;
            rate_reg       <= rate_next;
            mask_reg       <= mask_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/eapd_queue.sv
// small command queue between the front parser and the back end
// register file with read and write pointers; uses eapd_pkg
`default_nettype none

module eapd_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire eapd_pkg::eapd_cmd_t push_cmd,
    input  wire logic                pop,
    output logic                     full,
    output logic                     empty,
    output eapd_pkg::eapd_cmd_t      head_cmd
);
    import eapd_pkg::*;

    eapd_cmd_t        entry_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     count_reg, count_next;

    assign full     = (count_reg == (QAW+1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("command popped from an empty queue");

    a_level_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue level did not follow a lone push");
`endif

endmodule

`default_nettype wire

>>> rtl/eapd_back.sv
// back end: assembles samples and packet header fields from queued commands
// and holds the result in an output register; uses eapd_pkg
`default_nettype none

module eapd_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_empty,
    input  wire eapd_pkg::eapd_cmd_t    q_head,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output eapd_pkg::eapd_result_t      m_result,
    output logic [1:0]                  m_group,
    output logic [1:0]                  m_chan
);
    import eapd_pkg::*;

    logic [7:0]   block_reg;
    logic [12:0]  clock_reg;
    logic         mpf_reg;
    logic [19:0]  partial_reg;
    logic         out_valid_reg;
    eapd_result_t out_reg;
    logic [1:0]   out_group_reg;
    logic [1:0]   out_chan_reg;
    logic         out_free;
    logic         is_emit;

    assign out_free = !out_valid_reg || m_tready;
    assign is_emit  = (q_head.op == OP_EMIT);
    assign q_pop    = !q_empty && (!is_emit || out_free);

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;
    assign m_group  = out_group_reg;
    assign m_chan   = out_chan_reg;

    // header fields and partial sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_reg   <= 8'd0;
            clock_reg   <= 13'd0;
            mpf_reg     <= 1'b0;
            partial_reg <= 20'd0;
        end else if (q_pop) begin
            unique case (q_head.op)
                OP_BLOCK:  block_reg <= q_head.data;
                OP_CLK_LO: clock_reg[7:0] <= q_head.data;
                OP_CLK_HI: begin
                    clock_reg[11:8] <= q_head.data[3:0];
                    clock_reg[12]   <= q_head.data[5];
                    mpf_reg         <= q_head.data[4];
                end
                OP_SAMP0:  partial_reg <= {16'd0, q_head.data[7:4]};
                OP_SAMP1:  partial_reg[11:4] <= q_head.data;
                OP_SAMP2:  partial_reg[19:12] <= q_head.data;
                default: begin
                    partial_reg <= partial_reg;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= q_pop && is_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && is_emit) begin
            out_group_reg            <= q_head.grp;
            out_chan_reg             <= q_head.chan;
            out_reg.sample           <= {q_head.data[3:0], partial_reg};
            out_reg.validity_bit     <= q_head.data[4];
            out_reg.user_bit         <= q_head.data[5];
            out_reg.status_bit       <= q_head.data[6];
            out_reg.parity_bit       <= q_head.data[7];
            out_reg.block_number     <= block_reg;
            out_reg.audio_clock      <= clock_reg;
            out_reg.multi_frame_flag <= mpf_reg;
            out_reg.rate_code        <= q_head.rate;
        end
    end

endmodule

`default_nettype wire

>>> rtl/embedded_audio_packet_decoder.sv
// top level of the embedded audio packet decoder
// ties front parser, command queue and back end together; uses eapd_pkg
//
// usage:
//   s_ channel: one 10-bit ancillary word per item, s_tuser high on word 0 of
//   a packet. m_ channel: one item per active channel of an audio packet,
//   sample with V/U/C/P bits, block number, audio clock, mpf bit and rate.
//   cfg_we/cfg_index/cfg_wdata write the eight DID registers (audio ids of
//   groups 1..4 at 0..3, control ids at 4..7); write only while idle.
// timing:
//   one input item per cycle while the command queue is not full. a result
//   appears on m_tvalid once the fourth word of its channel is taken: the
//   front parser writes the queue at the accepting edge and the back end
//   then loads the output register from the queue.
// reset (aresetn low, synchronous): ids return to their defaults, all groups
//   become unconfigured, the queue empties and m_tvalid drops.
// stall: while m_tready is low the output register holds its item; the
//   four-entry command queue keeps taking words until full, then s_tready
//   goes low.
`default_nettype none

module embedded_audio_packet_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [9:0]  cfg_wdata,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // anc_word[9:0], zero pad
    input  wire logic        s_tuser,   // packet_start
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // sample[23:0], validity, user, status,
                                        // parity, block_number[7:0],
                                        // audio_clock[12:0], multi_frame_flag,
                                        // rate_code[1:0], zero pad
    output logic [3:0]       m_tuser    // group_index[1:0], channel_index[1:0]
);
    import eapd_pkg::*;

    eapd_cmd_t    push_cmd;
    eapd_cmd_t    head_cmd;
    eapd_result_t result;
    logic         q_push;
    logic         q_pop;
    logic         q_full;
    logic         q_empty;
    logic [1:0]   res_group;
    logic [1:0]   res_chan;

    eapd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    eapd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    eapd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result),
        .m_group  (res_group),
        .m_chan   (res_chan)
    );

    // pack result fields onto the stream
    assign m_tdata = {(M_DATA_W - RESULT_W)'(0), result};
    assign m_tuser = {res_chan, res_group};

endmodule

`default_nettype wire
